/* hw/rtl/rcem_pkg.sv */
// Shared types and constants for the ROI crop with elliptical mask.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rcem_pkg;

  // Frame and pixel limits
  localparam int MAX_FRAME_DIM = 2048;
  localparam int PIXEL_BITS    = 8;

  // Column counter covers 0..MAX_FRAME_DIM-1, row counter saturates at MAX_FRAME_DIM
  localparam int COL_W = $clog2(MAX_FRAME_DIM);
  localparam int ROW_W = COL_W + 1;

  // Register field widths
  localparam int CX_W  = 11;
  localparam int CY_W  = 11;
  localparam int RX_W  = 10;
  localparam int RY_W  = 10;
  localparam int FW_W  = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 3;

  // Common width for geometry sums and compares
  localparam int GEO_W = (ROW_W > FW_W) ? ROW_W + 1 : FW_W + 1;

  // Ellipse arithmetic widths
  localparam int SQ_W   = 2 * RX_W;
  localparam int PROD_W = 2 * SQ_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_RADIUS_X    = 3'd2,
    REG_RADIUS_Y    = 3'd3,
    REG_FRAME_WIDTH = 3'd4
  } reg_index_t;

  // Register reset values
  localparam logic [CX_W-1:0] CENTER_X_RST    = CX_W'(696);
  localparam logic [CY_W-1:0] CENTER_Y_RST    = CY_W'(520);
  localparam logic [RX_W-1:0] RADIUS_X_RST    = RX_W'(200);
  localparam logic [RY_W-1:0] RADIUS_Y_RST    = RY_W'(200);
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST = FW_W'(1392);

  // One window pixel waiting for the ellipse test
  typedef struct packed {
    logic [PIXEL_BITS-1:0] pix;
    logic [RX_W-1:0]       adx;
    logic [RY_W-1:0]       ady;
    logic                  last;
  } queue_entry_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* hw/rtl/rcem_front.sv */
// Front part: pixel acceptance, column/row counting and window classification.
// Depends on rcem_pkg; feeds window pixels into rcem_queue.
`timescale 1ns / 1ps

module rcem_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rcem_pkg::PIXEL_BITS-1:0] pixel_in,
  input  logic                            frame_start,
  input  logic [rcem_pkg::CX_W-1:0]       center_x,
  input  logic [rcem_pkg::CY_W-1:0]       center_y,
  input  logic [rcem_pkg::RX_W-1:0]       radius_x,
  input  logic [rcem_pkg::RY_W-1:0]       radius_y,
  input  logic [rcem_pkg::FW_W-1:0]       frame_width,
  input  rcem_pkg::queue_status_t         q_status,
  output logic                            q_push,
  output rcem_pkg::queue_entry_t          q_entry
);

  localparam int GW = rcem_pkg::GEO_W;
  localparam logic [GW-1:0] MAX_DIM = GW'(rcem_pkg::MAX_FRAME_DIM);

  logic [rcem_pkg::COL_W-1:0] column_count, column_count_next;
  logic [rcem_pkg::ROW_W-1:0] row_count, row_count_next;

  logic          accept;
  logic [GW-1:0] col, row, eff_w;
  logic [GW-1:0] cx, cy, rx, ry, x0, x1, y0, y1;
  logic          geo_ok, in_window;
  logic [GW-1:0] dx, dy;

  // Stall only when the queue cannot take another pixel
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  // Position of this pixel, restarted by the frame start flag
  assign col = frame_start ? '0 : GW'(column_count);
  assign row = frame_start ? '0 : GW'(row_count);

  // Effective frame width
  always_comb begin
    if (frame_width == '0 || GW'(frame_width) > MAX_DIM) begin
      eff_w = MAX_DIM;
    end else begin
      eff_w = GW'(frame_width);
    end
  end

  // Window bounds and geometry check
  assign cx = GW'(center_x);
  assign cy = GW'(center_y);
  assign rx = GW'(radius_x);
  assign ry = GW'(radius_y);
  assign x0 = cx - rx;
  assign x1 = cx + rx;
  assign y0 = cy - ry;
  assign y1 = cy + ry;

  assign geo_ok = (center_x != '0) && (center_y != '0) && (radius_x != '0) &&
                  (radius_y != '0) && (cx >= rx) && (cy >= ry) &&
                  (x1 <= eff_w) && (y1 <= MAX_DIM);

  assign in_window = geo_ok && (row < MAX_DIM) && (col >= x0) && (col < x1) &&
                     (row >= y0) && (row < y1);

  // Distance from the centre; bounded by the radius inside the window
  assign dx = (col >= cx) ? col - cx : cx - col;
  assign dy = (row >= cy) ? row - cy : cy - row;

  // Queue entry
  assign q_push        = accept && in_window;
  assign q_entry.pix   = pixel_in;
  assign q_entry.adx   = dx[rcem_pkg::RX_W-1:0];
  assign q_entry.ady   = dy[rcem_pkg::RY_W-1:0];
  assign q_entry.last  = (col == x1 - GW'(1)) && (row == y1 - GW'(1));

  // Advance counters: wrap column at the width, saturate row below the frame
  always_comb begin
    if (col + GW'(1) >= eff_w) begin
      column_count_next = '0;
      if (row < MAX_DIM) begin
        row_count_next = rcem_pkg::ROW_W'(row + GW'(1));
      end else begin
        row_count_next = rcem_pkg::ROW_W'(row);
      end
    end else begin
      column_count_next = rcem_pkg::COL_W'(col + GW'(1));
      row_count_next    = rcem_pkg::ROW_W'(row);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

`ifndef SYNTH
  // A push always comes from an accepted pixel with valid geometry
  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (accept && geo_ok))
    else $error("front pushed without an accepted in-window pixel");

  // Row counter never passes the below-frame mark
  a_row_saturates: assert property (@(posedge clk) disable iff (rst)
    GW'(row_count) <= MAX_DIM)
    else $error("row counter passed its saturation value");
`endif

endmodule

/* hw/rtl/rcem_queue.sv */
// Short queue of window pixels between the front and the back.
// Depends on rcem_pkg for the entry type and depth.
`timescale 1ns / 1ps

module rcem_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  rcem_pkg::queue_entry_t push_entry,
  input  logic                   pop,
  output rcem_pkg::queue_entry_t pop_entry,
  output rcem_pkg::queue_status_t status
);

  localparam int AW = rcem_pkg::QUEUE_AW;
  localparam logic [AW:0] DEPTH = (AW+1)'(rcem_pkg::QUEUE_DEPTH);

  rcem_pkg::queue_entry_t mem [rcem_pkg::QUEUE_DEPTH];

  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count, count_next;
  logic          do_push, do_pop;

  assign status.full  = (count == DEPTH);
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign pop_entry = mem[rd_ptr];

  // Store incoming entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - (AW+1)'(1);
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count_next;
    end
  end

`ifndef SYNTH
  // The front must never push into a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("push into full queue");

  // Pointers and count stay consistent
  a_count_matches_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == DEPTH) || (AW'(wr_ptr - rd_ptr) == count[AW-1:0]))
    else $error("queue count disagrees with pointers");
`endif

endmodule

/* hw/rtl/rcem_back.sv */
// Back part: pipelined integer ellipse test and output register.
// Depends on rcem_pkg; pops window pixels from rcem_queue.
`timescale 1ns / 1ps

module rcem_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rcem_pkg::RX_W-1:0]        radius_x,
  input  logic [rcem_pkg::RY_W-1:0]        radius_y,
  input  rcem_pkg::queue_status_t          q_status,
  input  rcem_pkg::queue_entry_t           q_entry,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rcem_pkg::PIXEL_BITS-1:0]  pixel_out,
  output logic                             window_last
);

  localparam int SW = rcem_pkg::SQ_W;
  localparam int PW = rcem_pkg::PROD_W;

  logic advance;

  // Stage 1: squares
  logic                            s1_valid;
  logic [rcem_pkg::PIXEL_BITS-1:0] s1_pix;
  logic                            s1_last;
  logic [SW-1:0]                   s1_dx2, s1_dy2, s1_rx2, s1_ry2;

  // Stage 2: cross products
  logic                            s2_valid;
  logic [rcem_pkg::PIXEL_BITS-1:0] s2_pix;
  logic                            s2_last;
  logic [PW-1:0]                   s2_t1, s2_t2, s2_lim;

  logic in_ellipse;

  // The whole pipeline moves when the output register is free or being taken
  assign advance = !out_valid || !out_stall;
  assign q_pop   = advance && !q_status.empty;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pix <= q_entry.pix;
      s1_last <= q_entry.last;
      s1_dx2 <= {{(SW-rcem_pkg::RX_W){1'b0}}, q_entry.adx} *
                {{(SW-rcem_pkg::RX_W){1'b0}}, q_entry.adx};
      s1_dy2 <= {{(SW-rcem_pkg::RY_W){1'b0}}, q_entry.ady} *
                {{(SW-rcem_pkg::RY_W){1'b0}}, q_entry.ady};
      s1_rx2 <= {{(SW-rcem_pkg::RX_W){1'b0}}, radius_x} *
                {{(SW-rcem_pkg::RX_W){1'b0}}, radius_x};
      s1_ry2 <= {{(SW-rcem_pkg::RY_W){1'b0}}, radius_y} *
                {{(SW-rcem_pkg::RY_W){1'b0}}, radius_y};

      s2_pix <= s1_pix;
      s2_last <= s1_last;
      s2_t1  <= {{SW{1'b0}}, s1_dx2} * {{SW{1'b0}}, s1_ry2};
      s2_t2  <= {{SW{1'b0}}, s1_dy2} * {{SW{1'b0}}, s1_rx2};
      s2_lim <= {{SW{1'b0}}, s1_rx2} * {{SW{1'b0}}, s1_ry2};

      pixel_out   <= in_ellipse ? s2_pix : '0;
      window_last <= s2_last;
    end
  end

  // Ellipse compare: one wide add and compare
  assign in_ellipse = ({1'b0, s2_t1} + {1'b0, s2_t2}) <= {1'b0, s2_lim};

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= q_pop;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

`ifndef SYNTH
  // A held result keeps the pipeline frozen, so stage 2 is not lost
  a_stage2_held: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !advance) |=> s2_valid)
    else $error("stage 2 item dropped during output stall");
`endif

endmodule

/* hw/rtl/roi_crop_ellipse_mask_unit.sv */
// Top level of the ROI crop with elliptical mask: configuration registers and
// wiring of front, queue and back. Depends on rcem_pkg, rcem_front, rcem_queue, rcem_back.
`timescale 1ns / 1ps

// Pixels enter in raster order, one per clock when the queue has room; the
// front counts column and row and forwards only pixels inside the window into
// a four-entry queue. The back computes squares and cross products in two
// pipeline stages and compares into an output register. The sustained rate is
// one pixel per cycle while out_stall is low, set by the front counter and by
// the back popping one queue entry a cycle.
// An output stall freezes the back; the front keeps accepting until the queue
// fills. Pixels outside the ellipse come out as zero, window_last marks the
// bottom-right corner, and nothing comes out while the geometry is invalid.
// Registers are written at any edge with cfg_write high and take effect at once.
module roi_crop_ellipse_mask_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rcem_pkg::PIXEL_BITS-1:0]   pixel_in,
  input  logic                              frame_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rcem_pkg::PIXEL_BITS-1:0]   pixel_out,
  output logic                              window_last,
  input  logic                              cfg_write,
  input  logic [rcem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcem_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [rcem_pkg::CX_W-1:0] center_x;
  logic [rcem_pkg::CY_W-1:0] center_y;
  logic [rcem_pkg::RX_W-1:0] radius_x;
  logic [rcem_pkg::RY_W-1:0] radius_y;
  logic [rcem_pkg::FW_W-1:0] frame_width;

  logic                    q_push, q_pop;
  rcem_pkg::queue_entry_t  q_in_entry, q_out_entry;
  rcem_pkg::queue_status_t q_status;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= rcem_pkg::CENTER_X_RST;
      center_y    <= rcem_pkg::CENTER_Y_RST;
      radius_x    <= rcem_pkg::RADIUS_X_RST;
      radius_y    <= rcem_pkg::RADIUS_Y_RST;
      frame_width <= rcem_pkg::FRAME_WIDTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rcem_pkg::REG_CENTER_X:    center_x    <= cfg_data[rcem_pkg::CX_W-1:0];
        rcem_pkg::REG_CENTER_Y:    center_y    <= cfg_data[rcem_pkg::CY_W-1:0];
        rcem_pkg::REG_RADIUS_X:    radius_x    <= cfg_data[rcem_pkg::RX_W-1:0];
        rcem_pkg::REG_RADIUS_Y:    radius_y    <= cfg_data[rcem_pkg::RY_W-1:0];
        rcem_pkg::REG_FRAME_WIDTH: frame_width <= cfg_data[rcem_pkg::FW_W-1:0];
        default: ;
      endcase
    end
  end

  rcem_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_in    (pixel_in),
    .frame_start (frame_start),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius_x    (radius_x),
    .radius_y    (radius_y),
    .frame_width (frame_width),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_entry     (q_in_entry)
  );

  rcem_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in_entry),
    .pop        (q_pop),
    .pop_entry  (q_out_entry),
    .status     (q_status)
  );

  rcem_back u_back (
    .clk         (clk),
    .rst         (rst),
    .radius_x    (radius_x),
    .radius_y    (radius_y),
    .q_status    (q_status),
    .q_entry     (q_out_entry),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out),
    .window_last (window_last)
  );

endmodule
